FILE: sv/rasc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rasc_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int DATA_BITS = 32;
   localparam int WIDE_BITS = 64;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_SUB   = 2'd1;
   localparam logic [1:0] FUNC_CMP   = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

endpackage
`default_nettype wire

FILE: sv/rasc_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rasc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] lhs_numerator;
   logic signed [31:0] lhs_denominator;
   logic signed [31:0] rhs_numerator;
   logic signed [31:0] rhs_denominator;

   modport source (output valid, func, lhs_numerator, lhs_denominator,
                   rhs_numerator, rhs_denominator, input ready);
   modport sink   (input valid, func, lhs_numerator, lhs_denominator,
                   rhs_numerator, rhs_denominator, output ready);
endinterface

interface rasc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_numerator;
   logic [30:0]        result_denominator;
   logic               equal_flag;
   logic [1:0]         status;

   modport source (output valid, result_numerator, result_denominator, equal_flag,
                   status, input ready);
   modport sink   (input valid, result_numerator, result_denominator, equal_flag,
                   status, output ready);
endinterface
`default_nettype wire

FILE: sv/rational_add_sub_compare.sv
`timescale 1ns / 1ps
`default_nettype none
// Adds, subtracts or compares two signed fractions, one beat at a time. A 64-bit restoring
// divider (one quotient bit a cycle) runs the Euclidean GCD of the denominators, two
// quotients, the GCD of the result and the common denominator, and two reducing divisions;
// a 32x32 multiplier forms the common denominator and the scaled terms. A compare skips the
// second GCD and its divisions; a zero denominator skips the GCDs, divisions and products.
// The result waits in an output register, so a stalled result holds the block only once the
// next item has finished as well. req.ready is high only while no item is at work.
module rational_add_sub_compare #(
   parameter int WORD_BITS = rasc_pkg::WORD_BITS_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   rasc_req_if.sink   req,
   rasc_rsp_if.source rsp
);

   localparam int W = rasc_pkg::WIDE_BITS;
   localparam int D = rasc_pkg::DATA_BITS;
   localparam logic [W-1:0] LIM = W'(1) << (WORD_BITS - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_GTEST = 4'd1;
   localparam logic [3:0] ST_GDIV  = 4'd2;
   localparam logic [3:0] ST_DV1   = 4'd3;
   localparam logic [3:0] ST_DV2   = 4'd4;
   localparam logic [3:0] ST_MUL0  = 4'd5;
   localparam logic [3:0] ST_MUL1  = 4'd6;
   localparam logic [3:0] ST_MUL2  = 4'd7;
   localparam logic [3:0] ST_COMB  = 4'd8;
   localparam logic [3:0] ST_DV3   = 4'd9;
   localparam logic [3:0] ST_DV4   = 4'd10;
   localparam logic [3:0] ST_FIN   = 4'd11;
   localparam logic [3:0] ST_OUT   = 4'd12;

   logic [3:0]   state_ff, state_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic         pass_ff, pass_in;
   logic [1:0]   op_ff, op_in;
   logic [D-1:0] n1a_ff, n1a_in, n2a_ff, n2a_in, d1a_ff, d1a_in, d2a_ff, d2a_in;
   logic         s1neg_ff, s1neg_in, s2neg_ff, s2neg_in;
   logic [D-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic [W-1:0] prod_ff, prod_in, lcm_ff, lcm_in, m1_ff, m1_in, mag_ff, mag_in;
   logic [W-1:0] rn_ff, rn_in;
   logic         neg_ff, neg_in;

   logic [W-1:0] dv_r_ff, dv_r_in;
   logic [W-1:0] dv_q_ff, dv_q_in, dv_d_ff, dv_d_in;
   logic [6:0]   dv_cnt_ff, dv_cnt_in;
   logic         dv_done;

   logic signed [31:0] w_num_ff, w_num_in;
   logic [30:0]        w_den_ff, w_den_in;
   logic               w_eq_ff, w_eq_in;
   logic [1:0]         w_st_ff, w_st_in;

   logic               o_valid_ff, o_valid_in;
   logic signed [31:0] o_num_ff, o_num_in;
   logic [30:0]        o_den_ff, o_den_in;
   logic               o_eq_ff, o_eq_in;
   logic [1:0]         o_st_ff, o_st_in;

   logic         dv_start;
   logic [W-1:0] dv_num, dv_den;
   logic [D-1:0] mul_a, mul_b;
   logic [W:0]   dv_t;
   logic         n1neg, n2neg;
   logic         ovf;

   assign dv_done = (dv_cnt_ff == 7'd0);
   assign dv_t    = {dv_r_ff, dv_q_ff[W-1]};

   always_comb begin
      mul_a = q2_ff;
      mul_b = d2a_ff;
      case (state_ff)
         ST_MUL1: begin
            mul_a = n1a_ff;
            mul_b = q1_ff;
         end
         ST_MUL2: begin
            mul_a = n2a_ff;
            mul_b = q2_ff;
         end
         default: begin
            mul_a = q2_ff;
            mul_b = d2a_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; pass_in = pass_ff; op_in = op_ff;
      n1a_in = n1a_ff; n2a_in = n2a_ff; d1a_in = d1a_ff; d2a_in = d2a_ff;
      s1neg_in = s1neg_ff; s2neg_in = s2neg_ff;
      q1_in = q1_ff; q2_in = q2_ff;
      prod_in = W'(mul_a) * W'(mul_b);
      lcm_in = lcm_ff; m1_in = m1_ff; mag_in = mag_ff; rn_in = rn_ff; neg_in = neg_ff;
      w_num_in = w_num_ff; w_den_in = w_den_ff; w_eq_in = w_eq_ff; w_st_in = w_st_ff;
      o_valid_in = o_valid_ff;
      o_num_in = o_num_ff; o_den_in = o_den_ff; o_eq_in = o_eq_ff; o_st_in = o_st_ff;
      dv_start = 1'b0;
      dv_num = a_ff;
      dv_den = b_ff;
      n1neg = s1neg_ff && (m1_ff != '0);
      n2neg = s2neg_ff && (prod_ff != '0);
      ovf = 1'b0;

      if (rsp.ready) begin
         o_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in = req.func;
               n1a_in = req.lhs_numerator[31] ? D'(-req.lhs_numerator) : req.lhs_numerator;
               n2a_in = req.rhs_numerator[31] ? D'(-req.rhs_numerator) : req.rhs_numerator;
               d1a_in = req.lhs_denominator[31] ? D'(-req.lhs_denominator)
                                                : req.lhs_denominator;
               d2a_in = req.rhs_denominator[31] ? D'(-req.rhs_denominator)
                                                : req.rhs_denominator;
               s1neg_in = req.lhs_numerator[31] ^ req.lhs_denominator[31];
               s2neg_in = req.rhs_numerator[31] ^ req.rhs_denominator[31];
               a_in = W'(d1a_in);
               b_in = W'(d2a_in);
               pass_in = 1'b0;
               w_num_in = '0; w_den_in = '0; w_eq_in = 1'b0; w_st_in = rasc_pkg::STATUS_OK;
               if (req.lhs_denominator == '0 || req.rhs_denominator == '0) begin
                  w_st_in = rasc_pkg::STATUS_ZERO_DEN;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_GTEST;
               end
            end
         end
         ST_GTEST: begin
            dv_start = 1'b1;
            if (b_ff == '0) begin
               if (!pass_ff) begin
                  dv_num = W'(d2a_ff);
                  dv_den = a_ff;
                  state_in = ST_DV1;
               end else begin
                  dv_num = mag_ff;
                  dv_den = a_ff;
                  state_in = ST_DV3;
               end
            end else begin
               state_in = ST_GDIV;
            end
         end
         ST_GDIV: begin
            if (dv_done) begin
               a_in = b_ff;
               b_in = dv_r_ff;
               state_in = ST_GTEST;
            end
         end
         ST_DV1: begin
            if (dv_done) begin
               q1_in = dv_q_ff[D-1:0];
               dv_start = 1'b1;
               dv_num = W'(d1a_ff);
               dv_den = a_ff;
               state_in = ST_DV2;
            end
         end
         ST_DV2: begin
            if (dv_done) begin
               q2_in = dv_q_ff[D-1:0];
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: begin
            lcm_in = prod_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            m1_in = prod_ff;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            if (op_ff != rasc_pkg::FUNC_ADD && op_ff != rasc_pkg::FUNC_SUB) begin
               w_eq_in = (m1_ff == prod_ff) && (n1neg == n2neg);
               state_in = ST_OUT;
            end else begin
               if (op_ff == rasc_pkg::FUNC_SUB) begin
                  n2neg = !n2neg;
               end
               if (n1neg == n2neg) begin
                  mag_in = m1_ff + prod_ff;
                  neg_in = n1neg;
               end else if (m1_ff >= prod_ff) begin
                  mag_in = m1_ff - prod_ff;
                  neg_in = n1neg;
               end else begin
                  mag_in = prod_ff - m1_ff;
                  neg_in = n2neg;
               end
               if (mag_in == '0) begin
                  w_den_in = 31'd1;
                  state_in = ST_OUT;
               end else begin
                  a_in = mag_in;
                  b_in = lcm_ff;
                  pass_in = 1'b1;
                  state_in = ST_GTEST;
               end
            end
         end
         ST_DV3: begin
            if (dv_done) begin
               rn_in = dv_q_ff;
               dv_start = 1'b1;
               dv_num = lcm_ff;
               dv_den = a_ff;
               state_in = ST_DV4;
            end
         end
         ST_DV4: begin
            if (dv_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            ovf = (dv_q_ff > LIM - W'(1)) || (neg_ff ? (rn_ff > LIM) : (rn_ff > LIM - W'(1)));
            if (ovf) begin
               w_st_in = rasc_pkg::STATUS_OVERFLOW;
            end else begin
               w_num_in = neg_ff ? D'(-rn_ff) : rn_ff[D-1:0];
               w_den_in = dv_q_ff[30:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!o_valid_ff || rsp.ready) begin
               o_valid_in = 1'b1;
               o_num_in = w_num_ff;
               o_den_in = w_den_ff;
               o_eq_in = w_eq_ff;
               o_st_in = w_st_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dv_r_in = dv_r_ff;
      dv_q_in = dv_q_ff;
      dv_d_in = dv_d_ff;
      dv_cnt_in = dv_cnt_ff;
      if (dv_start) begin
         dv_r_in = '0;
         dv_q_in = dv_num;
         dv_d_in = dv_den;
         dv_cnt_in = 7'(W);
      end else if (!dv_done) begin
         if (dv_t >= {1'b0, dv_d_ff}) begin
            dv_r_in = W'(dv_t - {1'b0, dv_d_ff});
            dv_q_in = {dv_q_ff[W-2:0], 1'b1};
         end else begin
            dv_r_in = dv_t[W-1:0];
            dv_q_in = {dv_q_ff[W-2:0], 1'b0};
         end
         dv_cnt_in = dv_cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         o_valid_ff <= 1'b0;
         dv_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         o_valid_ff <= o_valid_in;
         dv_cnt_ff <= dv_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; pass_ff <= pass_in; op_ff <= op_in;
      n1a_ff <= n1a_in; n2a_ff <= n2a_in; d1a_ff <= d1a_in; d2a_ff <= d2a_in;
      s1neg_ff <= s1neg_in; s2neg_ff <= s2neg_in;
      q1_ff <= q1_in; q2_ff <= q2_in;
      prod_ff <= prod_in; lcm_ff <= lcm_in; m1_ff <= m1_in; mag_ff <= mag_in;
      rn_ff <= rn_in; neg_ff <= neg_in;
      dv_r_ff <= dv_r_in; dv_q_ff <= dv_q_in; dv_d_ff <= dv_d_in;
      w_num_ff <= w_num_in; w_den_ff <= w_den_in; w_eq_ff <= w_eq_in; w_st_ff <= w_st_in;
      o_num_ff <= o_num_in; o_den_ff <= o_den_in; o_eq_ff <= o_eq_in; o_st_ff <= o_st_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = o_valid_ff;
   assign rsp.result_numerator = o_num_ff;
   assign rsp.result_denominator = o_den_ff;
   assign rsp.equal_flag = o_eq_ff;
   assign rsp.status = o_st_ff;

endmodule
`default_nettype wire

FILE: sv/rasc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rasc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_num,
   input wire logic [30:0] rsp_den,
   input wire logic        rsp_eq,
   input wire logic [1:0]  rsp_st
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_st != rasc_pkg::STATUS_OK |->
         rsp_num == '0 && rsp_den == '0 && !rsp_eq)
      else $error("error beat carries data");

   a_eq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_eq |-> rsp_num == '0 && rsp_den == '0)
      else $error("compare beat carries a fraction");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind rational_add_sub_compare rasc_checker u_rasc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_num   (rsp.result_numerator),
   .rsp_den   (rsp.result_denominator),
   .rsp_eq    (rsp.equal_flag),
   .rsp_st    (rsp.status)
);
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam int WORD_BITS    = rasc_pkg::WORD_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 300;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int LONG_HOLD    = 8000;

   typedef struct {
      logic [1:0]         func;
      logic signed [31:0] lhs_num;
      logic signed [31:0] lhs_den;
      logic signed [31:0] rhs_num;
      logic signed [31:0] rhs_den;
   } fraction_pair_type;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      logic               equal;
      logic [1:0]         status;
   } fraction_result_type;

   typedef struct {
      fraction_pair_type   pair;
      bit                  typed;
      fraction_result_type answer;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rasc_req_if req ();
   rasc_rsp_if rsp ();

   rational_add_sub_compare #(.WORD_BITS(WORD_BITS)) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fraction_result_type pending_results[$];
   stimulus_row_type    directed_rows[$];
   int                  error_count   = 0;
   int                  results_seen  = 0;
   int                  cycle_count   = 0;
   bit                  held_long     = 1'b0;

   function automatic logic [63:0] euclid_gcd(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic fraction_result_type combine_fractions(fraction_pair_type p);
      longint              n1, d1, n2, d2, s1, s2;
      logic [63:0]         g, lcm, m1, m2, mag, g2, rn, rd, lim;
      bit                  neg1, neg2, neg;
      fraction_result_type r;
      r = '{num: '0, den: '0, equal: 1'b0, status: rasc_pkg::STATUS_OK};
      n1 = longint'(p.lhs_num);
      d1 = longint'(p.lhs_den);
      n2 = longint'(p.rhs_num);
      d2 = longint'(p.rhs_den);
      if (d1 == 0 || d2 == 0) begin
         r.status = rasc_pkg::STATUS_ZERO_DEN;
         return r;
      end
      if (d1 < 0) begin
         d1 = -d1;
         n1 = -n1;
      end
      if (d2 < 0) begin
         d2 = -d2;
         n2 = -n2;
      end
      g   = euclid_gcd(d1, d2);
      lcm = (64'(d1) / g) * 64'(d2);
      s1  = n1 * longint'(64'(d2) / g);
      s2  = n2 * longint'(64'(d1) / g);
      if (p.func != rasc_pkg::FUNC_ADD && p.func != rasc_pkg::FUNC_SUB) begin
         r.equal = (s1 == s2);
         return r;
      end
      neg1 = s1 < 0;
      m1   = neg1 ? -s1 : s1;
      neg2 = s2 < 0;
      m2   = neg2 ? -s2 : s2;
      if (p.func == rasc_pkg::FUNC_SUB) neg2 = !neg2;
      if (neg1 == neg2) begin
         mag = m1 + m2;
         neg = neg1;
      end else if (m1 >= m2) begin
         mag = m1 - m2;
         neg = neg1;
      end else begin
         mag = m2 - m1;
         neg = neg2;
      end
      if (mag == 0) begin
         r.den = 31'd1;
         return r;
      end
      g2  = euclid_gcd(mag, lcm);
      rn  = mag / g2;
      rd  = lcm / g2;
      lim = 64'd1 << (WORD_BITS - 1);
      if (rd > lim - 1 || (neg ? rn > lim : rn > lim - 1)) begin
         r.status = rasc_pkg::STATUS_OVERFLOW;
         return r;
      end
      r.num = neg ? -rn[31:0] : rn[31:0];
      r.den = rd[30:0];
      return r;
   endfunction

   task automatic add_row(logic [1:0] f, int a, int b, int c, int d, bit typed,
                          int num = 0, int den = 0, bit eq = 0,
                          logic [1:0] st = rasc_pkg::STATUS_OK);
      stimulus_row_type row;
      row.pair   = '{func: f, lhs_num: a, lhs_den: b, rhs_num: c, rhs_den: d};
      row.typed  = typed;
      row.answer = '{num: num, den: den[30:0], equal: eq, status: st};
      directed_rows.push_back(row);
   endtask

   function automatic logic [31:0] random_operand(bit is_den);
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return is_den ? 32'($urandom_range(1, 1 << 16)) : -$urandom_range(0, 1 << 16);
         3:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
         default: return $urandom_range(0, 1) ? $urandom_range(1, 100) : -$urandom_range(1, 100);
      endcase
   endfunction

   function automatic fraction_pair_type random_pair();
      fraction_pair_type p;
      p.func    = 2'($urandom_range(0, 3));
      p.lhs_num = random_operand(1'b0);
      p.lhs_den = random_operand(1'b1);
      p.rhs_num = random_operand(1'b0);
      p.rhs_den = random_operand(1'b1);
      if ($urandom_range(0, 39) == 0) p.lhs_den = '0;
      if ($urandom_range(0, 39) == 0) p.rhs_den = '0;
      return p;
   endfunction

   // one item on the request channel, bursts with random gaps between them
   int burst_left = 0;
   task automatic send_pair(fraction_pair_type p, bit typed, fraction_result_type answer);
      int gap;
      bit taken;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req.valid           <= 1'b1;
      req.func            <= p.func;
      req.lhs_numerator   <= p.lhs_num;
      req.lhs_denominator <= p.lhs_den;
      req.rhs_numerator   <= p.rhs_num;
      req.rhs_denominator <= p.rhs_den;
      // ready only moves at the rising edge, so its value mid-cycle is the one the edge sees
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req.ready;
         @(posedge clock);
      end
      pending_results.push_back(typed ? answer : combine_fractions(p));
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // receiver: own stall pattern, one long hold once results are flowing
   int hold_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (!held_long && results_seen == 40) begin
         held_long = 1'b1;
         hold_left = LONG_HOLD;
         rsp.ready <= 1'b0;
      end else if (cycle_count % 3000 < 1000) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= $urandom_range(0, 2) != 0;
      end
   end

   always @(posedge clock) begin
      fraction_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result beat");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.result_numerator !== want.num) begin
               $error("result_numerator: expected %0d, got %0d", want.num,
                      rsp.result_numerator);
               error_count++;
            end
            if (rsp.result_denominator !== want.den) begin
               $error("result_denominator: expected %0d, got %0d", want.den,
                      rsp.result_denominator);
               error_count++;
            end
            if (rsp.equal_flag !== want.equal) begin
               $error("equal_flag: expected %0d, got %0d", want.equal, rsp.equal_flag);
               error_count++;
            end
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      fraction_result_type none;
      int                  wait_cycles;
      none = '{num: '0, den: '0, equal: 1'b0, status: rasc_pkg::STATUS_OK};
      req.valid           = 1'b0;
      req.func            = rasc_pkg::FUNC_ADD;
      req.lhs_numerator   = '0;
      req.lhs_denominator = '0;
      req.rhs_numerator   = '0;
      req.rhs_denominator = '0;

      // zero denominators on either side, every operation
      add_row(rasc_pkg::FUNC_ADD, 5, 0, 1, 2, 1, 0, 0, 0, rasc_pkg::STATUS_ZERO_DEN);
      add_row(rasc_pkg::FUNC_SUB, 5, 3, 1, 0, 1, 0, 0, 0, rasc_pkg::STATUS_ZERO_DEN);
      add_row(rasc_pkg::FUNC_CMP, 0, 0, 0, 0, 1, 0, 0, 0, rasc_pkg::STATUS_ZERO_DEN);
      add_row(rasc_pkg::FUNC_SPARE, 1, 0, 1, 1, 1, 0, 0, 0, rasc_pkg::STATUS_ZERO_DEN);
      add_row(rasc_pkg::FUNC_ADD, 1, 2, 1, 3, 1, 5, 6);
      add_row(rasc_pkg::FUNC_SUB, 1, 2, 1, 3, 1, 1, 6);
      add_row(rasc_pkg::FUNC_SUB, 1, 2, 2, 4, 1, 0, 1);
      add_row(rasc_pkg::FUNC_ADD, 0, 7, 0, -9, 1, 0, 1);
      add_row(rasc_pkg::FUNC_CMP, 1, 2, 2, 4, 1, 0, 0, 1);
      add_row(rasc_pkg::FUNC_CMP, 1, 2, 1, 3, 1, 0, 0, 0);
      add_row(rasc_pkg::FUNC_SPARE, -3, 6, 1, -2, 1, 0, 0, 1);
      add_row(rasc_pkg::FUNC_ADD, 3, -4, 1, 4, 1, -1, 2);
      // extremes of the operands and the overflow boundary
      add_row(rasc_pkg::FUNC_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1, 1, 0, 0, 0,
              rasc_pkg::STATUS_OVERFLOW);
      add_row(rasc_pkg::FUNC_ADD, 32'h8000_0000, 1, 0, 1, 1, 32'h8000_0000, 1);
      add_row(rasc_pkg::FUNC_ADD, 32'h8000_0000, -1, 0, 1, 1, 0, 0, 0,
              rasc_pkg::STATUS_OVERFLOW);
      add_row(rasc_pkg::FUNC_SUB, 32'h8000_0000, 1, 32'h7fff_ffff, 1, 1, 0, 0, 0,
              rasc_pkg::STATUS_OVERFLOW);
      add_row(rasc_pkg::FUNC_ADD, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe, 0);
      add_row(rasc_pkg::FUNC_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 0);
      add_row(rasc_pkg::FUNC_CMP, 32'h8000_0000, 32'h8000_0000, 1, 1, 0);
      add_row(rasc_pkg::FUNC_ADD, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 0);
      add_row(rasc_pkg::FUNC_SUB, 12345, -678, -987, 6543, 0);
      add_row(rasc_pkg::FUNC_CMP, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].answer);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain_results();
         send_pair(random_pair(), 1'b0, none);
      end
      drain_results();
      wait_cycles = 0;
      while (wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: rational_add_sub_compare.f
sv/rasc_pkg.sv
sv/rasc_if.sv
sv/rational_add_sub_compare.sv
sv/rasc_checker.sv
test/testbench.sv
